### rtl/core/slsf_pkg.sv
// ----------------------------------------------------------------------------
// slsf_pkg: shared types and constants for the sync/length/checksum deframer
// Holds the status codes, the result record, the register indexes, their reset values and the header bounds.
// ----------------------------------------------------------------------------
package slsf_pkg;

    // Frame check outcome
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_SYNC  = 3'd2,
        ST_BAD_LEN   = 3'd3,
        ST_TRUNCATED = 3'd4,
        ST_BAD_SUM   = 3'd5
    } status_t;

    // One reported result
    typedef struct packed {
        logic       route_local;
        logic [7:0] frame_length;
        logic [7:0] command;
        status_t    status;
    } result_t;

    // Configuration register indexes
    localparam logic CFG_SYNC_VALUE  = 1'b0;
    localparam logic CFG_LOCAL_GROUP = 1'b1;

    // Reset values of the configuration registers
    localparam logic [7:0] SYNC_RESET  = 8'h5E;
    localparam logic [3:0] GROUP_RESET = 4'd6;

    // Header bytes before the sync and length checks are made
    localparam logic [7:0] HEADER_LAST = 8'd4;
    localparam logic [7:0] MIN_LENGTH  = 8'd5;

endpackage

### rtl/core/slsf_core.sv
// ----------------------------------------------------------------------------
// slsf_core: per-byte frame parser
// Holds the frame tracking state and the configuration registers, and works
// out the result (if any) for each accepted byte in the same cycle.
// ----------------------------------------------------------------------------
module slsf_core
    import slsf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_accept,
    input  logic [7:0] in_byte,
    input  logic       in_end,
    input  logic       cfg_we,
    input  logic       cfg_addr,
    input  logic [7:0] cfg_wdata,
    output logic       res_valid,
    output result_t    res
);

    logic [7:0] sync_value_reg;
    logic [3:0] local_group_reg;

    logic [7:0] pos_reg,      pos_next;
    logic [7:0] exp_len_reg,  exp_len_next;
    logic [7:0] sum_reg,      sum_next;
    logic [7:0] cmd_reg,      cmd_next;
    logic       sync_ok_reg,  sync_ok_next;
    logic       first_reg,    first_next;
    logic       drop_reg,     drop_next;

    logic [7:0] sum_base;
    logic [8:0] pos_plus1;
    logic       good_sum;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_value_reg  <= SYNC_RESET;
            local_group_reg <= GROUP_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_SYNC_VALUE:  sync_value_reg  <= cfg_wdata;
                CFG_LOCAL_GROUP: local_group_reg <= cfg_wdata[3:0];
                default:         sync_value_reg  <= sync_value_reg;
            endcase
        end
    end

    assign sum_base  = (pos_reg == 8'd0) ? 8'd0 : sum_reg;
    assign pos_plus1 = {1'b0, pos_reg} + 9'd1;
    assign good_sum  = (in_byte == sum_reg);

    // Next state and result for the byte on the input
    always_comb begin
        pos_next     = pos_reg;
        exp_len_next = exp_len_reg;
        sum_next     = sum_reg;
        cmd_next     = cmd_reg;
        sync_ok_next = sync_ok_reg;
        first_next   = first_reg;
        drop_next    = drop_reg;
        res_valid    = 1'b0;
        res          = '{route_local: 1'b0, frame_length: 8'd0,
                         command: 8'd0, status: ST_OK};

        if (drop_reg) begin
            // discard until the chunk closes
            if (in_end) begin
                pos_next   = 8'd0;
                sum_next   = 8'd0;
                first_next = 1'b1;
                drop_next  = 1'b0;
            end
        end else if (pos_reg < HEADER_LAST) begin
            // header bytes: capture fields, accumulate checksum
            if (pos_reg == 8'd0) sync_ok_next = (in_byte == sync_value_reg);
            if (pos_reg == 8'd1) cmd_next = in_byte;
            if (pos_reg == 8'd3) exp_len_next = in_byte;
            sum_next = sum_base + in_byte;
            if (in_end) begin
                pos_next   = 8'd0;
                sum_next   = 8'd0;
                first_next = 1'b1;
                drop_next  = 1'b0;
                if (first_reg) begin
                    res_valid  = 1'b1;
                    res.status = ST_SHORT;
                end
            end else begin
                pos_next = pos_plus1[7:0];
            end
        end else begin
            res.status = ST_OK;
            if (pos_reg == HEADER_LAST && !sync_ok_reg) begin
                res_valid  = 1'b1;
                res.status = ST_BAD_SYNC;
            end else if (pos_reg == HEADER_LAST && exp_len_reg < MIN_LENGTH) begin
                res_valid  = 1'b1;
                res.status = ST_BAD_LEN;
            end else if (pos_plus1 == {1'b0, exp_len_reg}) begin
                // checksum byte
                res_valid = 1'b1;
                if (good_sum) begin
                    res.status       = ST_OK;
                    res.command      = cmd_reg;
                    res.frame_length = exp_len_reg;
                    res.route_local  = (cmd_reg[7:4] == local_group_reg);
                end else begin
                    res.status = ST_BAD_SUM;
                end
            end else if (in_end) begin
                res_valid  = 1'b1;
                res.status = ST_TRUNCATED;
            end else begin
                sum_next = sum_reg + in_byte;
                pos_next = pos_plus1[7:0];
            end

            // state after a reported result
            if (res_valid) begin
                if (in_end) begin
                    pos_next   = 8'd0;
                    sum_next   = 8'd0;
                    first_next = 1'b1;
                    drop_next  = 1'b0;
                end else if (res.status == ST_OK) begin
                    pos_next   = 8'd0;
                    sum_next   = 8'd0;
                    first_next = 1'b0;
                end else begin
                    drop_next = 1'b1;
                    pos_next  = 8'd0;
                end
            end
        end
    end

    // Frame tracking state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= 8'd0;
            exp_len_reg <= 8'd0;
            sum_reg     <= 8'd0;
            cmd_reg     <= 8'd0;
            sync_ok_reg <= 1'b0;
            first_reg   <= 1'b1;
            drop_reg    <= 1'b0;
        end else if (in_accept) begin
            pos_reg     <= pos_next;
            exp_len_reg <= exp_len_next;
            sum_reg     <= sum_next;
            cmd_reg     <= cmd_next;
            sync_ok_reg <= sync_ok_next;
            first_reg   <= first_next;
            drop_reg    <= drop_next;
        end
    end

    // While dropping, the frame position is held at the start
    a_drop_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        drop_reg |-> (pos_reg == 8'd0))
        else $error("position not cleared while dropping");

    // A good frame is never reported with a length below the minimum
    a_ok_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && res_valid && res.status == ST_OK) |-> (res.frame_length >= MIN_LENGTH))
        else $error("good frame with short length");

    // A chunk-ending byte always leaves the parser out of drop mode
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && in_end) |=> (!drop_reg && first_reg && pos_reg == 8'd0))
        else $error("chunk end did not restart parsing");

endmodule

### rtl/core/sync_length_sum_frame_checker.sv
// ----------------------------------------------------------------------------
// sync_length_sum_frame_checker: byte-stream deframer with sync and checksum
// Checks sync byte, length field and 8-bit additive checksum of each frame.
// ----------------------------------------------------------------------------
// One received byte is taken per clock on the slave stream, tlast marking the
// end of a receive chunk. The per-byte parser updates its state in the cycle
// the byte is accepted, and any result is registered before it reaches the
// master stream. A two-entry output stage (result register plus skid register)
// keeps the input flowing at one byte per cycle while a result waits; input
// is held off only when both entries are full. Result tdata carries status,
// command and frame length; tuser carries the local-routing flag. Error
// results carry zero in command, length and route fields.
// ----------------------------------------------------------------------------
module sync_length_sum_frame_checker
    import slsf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // chunk_end
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [2:0] status, [10:3] command,
                                        // [18:11] frame_length, [23:19] zero
    output logic        m_axis_tuser,   // route_local
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    logic    in_accept;
    logic    core_valid;
    result_t core_res;
    logic    new_res;
    logic    out_take;

    logic    out_valid_reg,  out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg,   out_data_next;
    result_t skid_data_reg,  skid_data_next;

    assign in_accept = s_axis_tvalid && s_axis_tready;

    slsf_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_axis_tdata),
        .in_end    (s_axis_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .res_valid (core_valid),
        .res       (core_res)
    );

    assign new_res       = in_accept && core_valid;
    assign out_take      = out_valid_reg && m_axis_tready;
    assign s_axis_tready = !skid_valid_reg;

    // Output register and skid stage
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_take || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = new_res;
                out_data_next  = core_res;
            end
        end else if (new_res) begin
            skid_data_next  = core_res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_data_reg.frame_length, out_data_reg.command,
                            out_data_reg.status};
    assign m_axis_tuser  = out_data_reg.route_local;

    // The skid entry is only ever filled behind a waiting result
    a_skid_behind: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // A result produced while the output stalls lands in the skid entry
    a_no_loss: assert property (@(posedge aclk) disable iff (!aresetn)
        (new_res && out_valid_reg && !m_axis_tready) |=> skid_valid_reg)
        else $error("result lost while output stalled");

    // Error results carry no frame details
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && out_data_reg.status != ST_OK) |->
        (out_data_reg.command == 8'd0 && out_data_reg.frame_length == 8'd0 &&
         !out_data_reg.route_local))
        else $error("error result with frame fields set");

endmodule
